[design/positional_insert_erase_list_macros.svh]
// assertion macros shared by the list rtl
`ifndef POSITIONAL_INSERT_ERASE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_ERASE_LIST_MACROS_SVH

// same-cycle implication, disabled in reset
`define PIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("list assertion failed");

// next-cycle implication, disabled in reset
`define PIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("list assertion failed");

`endif

[design/pil_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pil_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int ELEM_WIDTH_DEF = 32;

	localparam int OPCODE_W = 2;
	localparam int INDEX_W  = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	typedef enum logic [OPCODE_W-1:0] {
		OP_READ   = 2'd0,
		OP_INSERT = 2'd1,
		OP_ERASE  = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic               ins;
		logic               ers;
		logic [INDEX_W-1:0] idx;
	} cell_cmd_t;

endpackage
`default_nettype wire

[design/pil_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module pil_cell #(
	parameter int unsigned POS        = 0,
	parameter int          ELEM_WIDTH = pil_pkg::ELEM_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire pil_pkg::cell_cmd_t    cmd,
	input  wire logic [ELEM_WIDTH-1:0] ins_val,
	input  wire logic [ELEM_WIDTH-1:0] left,
	input  wire logic [ELEM_WIDTH-1:0] right,
	output logic      [ELEM_WIDTH-1:0] elem_q
);
	import pil_pkg::*;

	logic at_idx;
	logic above_idx;

	assign at_idx    = (32'(cmd.idx) == POS);
	assign above_idx = (32'(cmd.idx) < POS);

	// insert: slot at index takes the new value, slots above take from below
	// erase: slots from index up take from above
	always_ff @(posedge clk) begin
		if (cmd.ins && at_idx) begin
			elem_q <= ins_val;
		end else if (cmd.ins && above_idx) begin
			elem_q <= left;
		end else if (cmd.ers && (at_idx || above_idx)) begin
			elem_q <= right;
		end
	end

endmodule
`default_nettype wire

[design/positional_insert_erase_list.sv]
// the result item is registered and appears on m_* in the cycle after its input item is accepted
// throughput: one item per cycle while m_tready is high; s_tready falls only while
//   a result waits in the output register and m_tready is low
// the row of cells shifts all later elements in parallel for insert and erase
// reset clears the element count and the output valid; element cells are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "positional_insert_erase_list_macros.svh"
module positional_insert_erase_list #(
	parameter int CAPACITY   = pil_pkg::CAPACITY_DEF,
	parameter int ELEM_WIDTH = pil_pkg::ELEM_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// opcode[1:0], index[6:2], elem_value[38:7], zero fill[39]
	input  wire logic [pil_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// read_value[31:0], status[33:32], count[38:34], is_empty[39]
	output logic      [pil_pkg::M_TDATA_W-1:0] m_tdata
);
	import pil_pkg::*;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = $clog2(CAPACITY);

	opcode_t              op;
	logic [INDEX_W-1:0]   idx;
	logic [VALUE_W-1:0]   elem_value;
	logic                 s_acc;

	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_nxt;
	status_t              st;
	logic [VALUE_W-1:0]   rd_val;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 idx_lt_cnt;
	logic                 idx_gt_cnt;
	logic                 ins_ok;
	logic                 ers_ok;
	cell_cmd_t            cmd;
	logic [ELEM_WIDTH-1:0] ins_val;
	logic [ELEM_WIDTH-1:0] cell_q [CAPACITY];

	logic [VALUE_W-1:0]   rd_val_q;
	status_t              st_q;
	logic [COUNT_W-1:0]   cnt_out_q;
	logic                 empty_q;
	logic                 m_tvalid_q;

	assign op         = opcode_t'(s_tdata[1:0]);
	assign idx        = s_tdata[6:2];
	assign elem_value = s_tdata[38:7];

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	assign idx_lt_cnt = (32'(idx) < 32'(cnt_q));
	assign idx_gt_cnt = (32'(idx) > 32'(cnt_q));
	assign ins_ok     = (op == OP_INSERT) && !idx_gt_cnt && (32'(cnt_q) != CAPACITY);
	assign ers_ok     = (op == OP_ERASE) && (cnt_q != '0) && idx_lt_cnt;
	assign rd_addr    = ADDR_W'(idx);
	assign ins_val    = ELEM_WIDTH'(elem_value);

	always_comb begin
		cmd.ins = s_acc && ins_ok;
		cmd.ers = s_acc && ers_ok;
		cmd.idx = idx;
	end

	always_comb begin
		st      = ST_OK;
		rd_val  = '0;
		cnt_nxt = cnt_q;
		case (op)
			OP_READ: begin
				if (!idx_lt_cnt) begin
					st = ST_RANGE;
				end else begin
					rd_val = VALUE_W'(cell_q[rd_addr]);
				end
			end
			OP_INSERT: begin
				if (idx_gt_cnt) begin
					st = ST_RANGE;
				end else if (!ins_ok) begin
					st = ST_FULL;
				end else begin
					cnt_nxt = cnt_q + CNT_W'(1);
				end
			end
			OP_ERASE: begin
				if (cnt_q == '0) begin
					st = ST_EMPTY;
				end else if (!idx_lt_cnt) begin
					st = ST_RANGE;
				end else begin
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		pil_cell #(
			.POS        (i),
			.ELEM_WIDTH (ELEM_WIDTH)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.ins_val (ins_val),
			.left    (cell_q[(i == 0) ? 0 : i - 1]),
			.right   (cell_q[(i == CAPACITY - 1) ? i : i + 1]),
			.elem_q  (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				cnt_q      <= cnt_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each accepted item
	always_ff @(posedge clk) begin
		if (s_acc) begin
			rd_val_q  <= rd_val;
			st_q      <= st;
			cnt_out_q <= COUNT_W'(cnt_nxt);
			empty_q   <= (cnt_nxt == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {empty_q, cnt_out_q, st_q, rd_val_q};

	`PIL_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, 32'(cnt_q) <= CAPACITY)
	`PIL_ASSERT_IMP(a_empty_flag, clk, arst_n, m_tvalid_q, empty_q == (cnt_q == '0))
	`PIL_ASSERT_NXT(a_clear, clk, arst_n, s_acc && (op == OP_CLEAR), cnt_q == '0)
	`PIL_ASSERT_NXT(a_ins_grow, clk, arst_n, cmd.ins, cnt_q == $past(cnt_q) + CNT_W'(1))
	`PIL_ASSERT_IMP(a_one_shift, clk, arst_n, 1'b1, !(cmd.ins && cmd.ers))

endmodule
`default_nettype wire

[sim/positional_insert_erase_list_tb.sv]
`timescale 1ns / 1ps
module positional_insert_erase_list_tb;
	import pil_pkg::*;

	localparam int CAP = CAPACITY_DEF;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		status_t            status;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
	} list_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	positional_insert_erase_list dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// mirror of the list contents, kept in step with accepted items
	logic [VALUE_W-1:0] list_cells [CAP];
	int                 list_len;
	list_result_t       pending_results [$];

	bit idle_en;
	int sink_hold;
	int mismatches;
	int results_seen;
	int op_counts [4];
	int full_refusals;
	int empty_refusals;
	int range_refusals;
	int max_len;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic list_result_t apply_list_op(opcode_t op, int idx, logic [VALUE_W-1:0] val);
		list_result_t r;
		r = '0;
		r.status = ST_OK;
		case (op)
		OP_READ: begin
			if (idx >= list_len)
				r.status = ST_RANGE;
			else
				r.read_value = list_cells[idx];
		end
		OP_INSERT: begin
			// range is checked ahead of full
			if (idx > list_len) begin
				r.status = ST_RANGE;
			end else if (list_len >= CAP) begin
				r.status = ST_FULL;
			end else begin
				for (int i = list_len; i > idx; i--)
					list_cells[i] = list_cells[i-1];
				list_cells[idx] = val;
				list_len++;
			end
		end
		OP_ERASE: begin
			// empty is checked ahead of range
			if (list_len == 0) begin
				r.status = ST_EMPTY;
			end else if (idx >= list_len) begin
				r.status = ST_RANGE;
			end else begin
				for (int i = idx; i < list_len - 1; i++)
					list_cells[i] = list_cells[i+1];
				list_len--;
			end
		end
		default: begin
			list_len = 0;
		end
		endcase
		r.count = list_len[COUNT_W-1:0];
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	task automatic send_op(opcode_t op, int idx, logic [VALUE_W-1:0] val);
		list_result_t r;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, val, idx[INDEX_W-1:0], op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = apply_list_op(op, idx, val);
		pending_results.push_back(r);
		op_counts[op]++;
		if (r.status == ST_FULL)
			full_refusals++;
		if (r.status == ST_EMPTY)
			empty_refusals++;
		if (r.status == ST_RANGE)
			range_refusals++;
		if (list_len > max_len)
			max_len = list_len;
	endtask

	function automatic int pick_index(opcode_t op);
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 16);
		if (op == OP_INSERT)
			return $urandom_range(0, list_len);
		if (list_len == 0 || op == OP_CLEAR)
			return $urandom_range(0, 16);
		return $urandom_range(0, list_len - 1);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return $urandom;
		endcase
	endfunction

	// sink side: random stall bursts on m_tready
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			sink_hold <= $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.read_value = m_tdata[31:0];
			got.status = status_t'(m_tdata[33:32]);
			got.count = m_tdata[38:34];
			got.is_empty = m_tdata[39];
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %0d: value %h status %s count %0d empty %0b",
						results_seen, got.read_value, got.status.name(), got.count,
						got.is_empty);
			end else begin
				want = pending_results.pop_front();
				if (got.read_value !== want.read_value || got.status !== want.status ||
						got.count !== want.count || got.is_empty !== want.is_empty) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on result %0d: expected %h %s count %0d empty %0b",
							results_seen, want.read_value, want.status.name(), want.count,
							want.is_empty);
						$display("  got %h %s count %0d empty %0b",
							got.read_value, got.status.name(), got.count, got.is_empty);
					end
				end
			end
		end
	end

	task automatic test_empty_list();
		send_op(OP_READ, 0, '0);
		send_op(OP_READ, 16, '1);
		send_op(OP_ERASE, 0, '0);
		send_op(OP_ERASE, 16, '0);
		send_op(OP_INSERT, 1, 32'h1234_5678);
		send_op(OP_INSERT, 16, '1);
		send_op(OP_CLEAR, 0, '0);
	endtask

	task automatic test_edge_positions();
		send_op(OP_INSERT, 0, '1);
		send_op(OP_INSERT, 0, '0);
		send_op(OP_INSERT, 2, 32'hA5A5_A5A5);
		send_op(OP_INSERT, 1, 32'h5A5A_5A5A);
		for (int i = 0; i < 4; i++)
			send_op(OP_READ, i, '0);
		// first index past the end
		send_op(OP_READ, 4, '0);
		send_op(OP_INSERT, 5, 32'hDEAD_BEEF);
		send_op(OP_ERASE, 4, '0);
		send_op(OP_ERASE, 1, '0);
		send_op(OP_ERASE, 0, '0);
		send_op(OP_ERASE, list_len - 1, '0);
		send_op(OP_READ, 0, '0);
		send_op(OP_CLEAR, 16, '1);
		// cells keep their bits after clear but are no longer readable
		send_op(OP_READ, 0, '0);
	endtask

	task automatic test_full_list(int rounds);
		for (int n = 0; n < rounds; n++) begin
			while (list_len < CAP)
				send_op(OP_INSERT, $urandom_range(0, list_len), pick_value());
			send_op(OP_INSERT, 0, pick_value());
			send_op(OP_INSERT, 16, pick_value());
			send_op(OP_READ, 15, '0);
			send_op(OP_READ, 16, '0);
			send_op(OP_ERASE, 16, '0);
			for (int i = 0; i < 4; i++)
				send_op(OP_READ, $urandom_range(0, CAP - 1), '0);
			while (list_len > 0)
				send_op(OP_ERASE, $urandom_range(0, list_len - 1), '0);
			send_op(OP_ERASE, $urandom_range(0, 16), '0);
		end
	endtask

	task automatic test_random_ops(int n_items, bit vary_idle);
		bit      grow;
		int      w;
		opcode_t op;
		grow = 1'b1;
		for (int n = 0; n < n_items; n++) begin
			if (vary_idle && n % 64 == 0)
				idle_en = ($urandom_range(0, 3) != 0);
			if (list_len == CAP)
				grow = 1'b0;
			else if (list_len == 0)
				grow = 1'b1;
			else if ($urandom_range(0, 19) == 0)
				grow = !grow;
			w = $urandom_range(0, 99);
			if (w < 2)
				op = OP_CLEAR;
			else if (w < 55)
				op = grow ? OP_INSERT : OP_ERASE;
			else if (w < 80)
				op = OP_READ;
			else
				op = grow ? OP_ERASE : OP_INSERT;
			send_op(op, pick_index(op), pick_value());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		list_len = 0;
		sink_hold = 0;
		idle_en = 1'b1;
		for (int i = 0; i < CAP; i++)
			list_cells[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edge_positions();
		test_full_list(3);
		test_random_ops(340, 1'b1);
		// closing stretch at full rate on both sides
		idle_en = 1'b0;
		test_random_ops(60, 1'b0);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d reads, %0d inserts, %0d erases, %0d clears; %0d results checked",
			op_counts[OP_READ], op_counts[OP_INSERT], op_counts[OP_ERASE],
			op_counts[OP_CLEAR], results_seen);
		$display("longest list %0d, refused: %0d full, %0d empty, %0d out of range",
			max_len, full_refusals, empty_refusals, range_refusals);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/pil_pkg.sv
design/pil_cell.sv
design/positional_insert_erase_list.sv
sim/positional_insert_erase_list_tb.sv
